// File: rtl/overlap_layer_placement_unit_defines.svh
// Assertion macros shared by the overlap layer placement RTL.
`ifndef OVERLAP_LAYER_PLACEMENT_UNIT_DEFINES_SVH
`define OVERLAP_LAYER_PLACEMENT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OLP_ASSERT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("olp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define OLP_ASSERT_NEXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("olp assertion failed");

`endif

// File: rtl/olp_pkg.sv
// Types, constants and sequencer states for the overlap layer placement unit.
package olp_pkg;

	localparam int unsigned DEF_MAX_LAYERS = 16;
	localparam int unsigned DEF_MAX_SLOTS  = 16;

	typedef struct packed {
		logic signed [15:0] center_x;
		logic signed [15:0] center_y;
		logic [14:0]        rect_width;
		logic [14:0]        rect_height;
	} rect_t;

	typedef struct packed {
		logic [3:0] placed_layer;
		logic [3:0] placed_slot;
		logic [4:0] layers_used;
		logic [4:0] slots_used;
		logic       rejected;
	} result_t;

	localparam int unsigned RECT_W = $bits(rect_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COUNT,
		ST_DECIDE
	} state_t;

endpackage

// File: rtl/olp_ram.sv
// Generic single-port-write, registered-read RAM.
module olp_ram #(
	parameter int unsigned WIDTH  = 8,
	parameter int unsigned DEPTH  = 16,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/olp_overlap.sv
// Overlap test between a stored rectangle and the incoming one.
module olp_overlap (
	input  olp_pkg::rect_t stored,
	input  olp_pkg::rect_t probe,
	output logic           hit
);

	import olp_pkg::*;

	logic [16:0] dx;
	logic [16:0] dy;
	logic [16:0] adx;
	logic [16:0] ady;
	logic [15:0] wsum;
	logic [15:0] hsum;

	// Twice the center distance must be strictly below the summed extents on both axes.
	always_comb begin
		dx   = {stored.center_x[15], stored.center_x} - {probe.center_x[15], probe.center_x};
		dy   = {stored.center_y[15], stored.center_y} - {probe.center_y[15], probe.center_y};
		adx  = dx[16] ? (17'd0 - dx) : dx;
		ady  = dy[16] ? (17'd0 - dy) : dy;
		wsum = {1'b0, stored.rect_width} + {1'b0, probe.rect_width};
		hsum = {1'b0, stored.rect_height} + {1'b0, probe.rect_height};
		hit  = ({adx, 1'b0} < {2'b00, wsum}) && ({ady, 1'b0} < {2'b00, hsum});
	end

endmodule

// File: rtl/overlap_layer_placement_unit.sv
// After a start transaction is accepted, the sequencer scans every grid entry of the L layers
// and C columns in use, drains, counts the fill of the target layer, decides and strobes done;
// with an empty grid it goes straight to the decide step. One rectangle at a time: busy is high
// while the sequencer is away from idle and drops as done rises. The single RAM read port and
// overlap comparator visit one stored entry per cycle. The receiver cannot stall.
// Reset (arst_n low) empties the grid at once: counts and occupancy bits clear, no sweep.
`include "overlap_layer_placement_unit_defines.svh"

module overlap_layer_placement_unit #(
	parameter int unsigned MAX_LAYERS = olp_pkg::DEF_MAX_LAYERS,
	parameter int unsigned MAX_SLOTS  = olp_pkg::DEF_MAX_SLOTS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  olp_pkg::rect_t   rect,
	output logic             done,
	output olp_pkg::result_t result
);

	import olp_pkg::*;

	localparam int unsigned GRID = MAX_LAYERS * MAX_SLOTS;
	localparam int unsigned AW   = (GRID > 1) ? $clog2(GRID) : 1;
	localparam int unsigned BW   = $clog2(GRID + 1);
	localparam int unsigned LCW  = $clog2(MAX_LAYERS + 1);
	localparam int unsigned SCW  = $clog2(MAX_SLOTS + 1);
	localparam int unsigned LIW  = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
	localparam int unsigned SIW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

	state_t          state_q, state_d;
	rect_t           rect_q;
	logic [LCW-1:0]  lc_q;
	logic [SCW-1:0]  cc_q;
	logic [LIW-1:0]  lidx_q;
	logic [SIW-1:0]  sidx_q;
	logic [BW-1:0]   row_base_q;
	logic [BW-1:0]   tbase_q;
	logic [LCW-1:0]  target_q;
	logic [SCW-1:0]  fill_q;
	logic            chk_s1;
	logic [LIW-1:0]  layer_s1;
	logic [BW-1:0]   rowbase_s1;
	logic [GRID-1:0] valid_q;
	result_t         result_q;
	logic            done_q;

	logic            accept;
	logic            scan_act;
	logic            count_act;
	logic            decide_act;
	logic            row_last;
	logic            layer_last;
	logic [BW-1:0]   base_sel;
	logic [AW-1:0]   raddr;
	logic [AW-1:0]   waddr;
	rect_t           stored;
	logic            hit;
	logic            new_layer;
	logic            grow;
	logic [LCW:0]    new_layers;
	logic [SCW:0]    new_cols;
	logic [SCW-1:0]  slot;
	logic            reject;
	logic            wr_en;

	assign accept     = start && !busy;
	assign row_last   = (sidx_q == SIW'(cc_q - SCW'(1)));
	assign layer_last = (lidx_q == LIW'(lc_q - LCW'(1)));
	assign base_sel   = count_act ? tbase_q : row_base_q;
	assign raddr      = AW'(base_sel + BW'(sidx_q));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (lc_q == '0) ? ST_DECIDE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (row_last && layer_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_COUNT;
			ST_COUNT: begin
				if (row_last) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		scan_act   = 1'b0;
		count_act  = 1'b0;
		decide_act = 1'b0;
		busy       = 1'b1;
		unique case (state_q)
			ST_IDLE:   busy       = 1'b0;
			ST_SCAN:   scan_act   = 1'b1;
			ST_DRAIN:  ;
			ST_COUNT:  count_act  = 1'b1;
			ST_DECIDE: decide_act = 1'b1;
			default:   busy       = 1'b0;
		endcase
	end

	olp_ram #(
		.WIDTH (RECT_W),
		.DEPTH (GRID)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (waddr),
		.wdata (rect_q),
		.raddr (raddr),
		.rdata (stored)
	);

	olp_overlap u_overlap (
		.stored (stored),
		.probe  (rect_q),
		.hit    (hit)
	);

	// The slot is always the fill of the target layer, since layers fill from slot zero.
	always_comb begin
		new_layer  = (target_q == lc_q);
		new_layers = {1'b0, lc_q} + (LCW + 1)'(new_layer);
		grow       = new_layer ? (cc_q == '0) : (fill_q == cc_q);
		new_cols   = {1'b0, cc_q} + (SCW + 1)'(grow);
		slot       = new_layer ? '0 : fill_q;
		reject     = (new_layers > (LCW + 1)'(MAX_LAYERS)) ||
		             (new_cols > (SCW + 1)'(MAX_SLOTS));
		waddr      = AW'(tbase_q + BW'(slot));
		wr_en      = decide_act && !reject;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			lc_q       <= '0;
			cc_q       <= '0;
			lidx_q     <= '0;
			sidx_q     <= '0;
			row_base_q <= '0;
			tbase_q    <= '0;
			target_q   <= '0;
			fill_q     <= '0;
			chk_s1     <= 1'b0;
			valid_q    <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= decide_act;
			chk_s1  <= scan_act && valid_q[raddr];

			if (accept) begin
				lidx_q     <= '0;
				sidx_q     <= '0;
				row_base_q <= '0;
				tbase_q    <= '0;
				target_q   <= '0;
				fill_q     <= '0;
			end

			if (scan_act) begin
				if (row_last) begin
					sidx_q     <= '0;
					lidx_q     <= lidx_q + LIW'(1);
					row_base_q <= row_base_q + BW'(MAX_SLOTS);
				end else begin
					sidx_q <= sidx_q + SIW'(1);
				end
			end

			// Layers are scanned in ascending order, so the last hit is the deepest one.
			if (chk_s1 && hit) begin
				target_q <= LCW'(layer_s1) + LCW'(1);
				tbase_q  <= rowbase_s1 + BW'(MAX_SLOTS);
			end

			if (count_act) begin
				sidx_q <= row_last ? '0 : (sidx_q + SIW'(1));
				if ((target_q < lc_q) && valid_q[raddr]) begin
					fill_q <= fill_q + SCW'(1);
				end
			end

			if (wr_en) begin
				valid_q[waddr] <= 1'b1;
				lc_q           <= LCW'(new_layers);
				cc_q           <= SCW'(new_cols);
			end
		end
	end

	always_ff @(posedge clk) begin
		rect_q     <= accept ? rect : rect_q;
		layer_s1   <= lidx_q;
		rowbase_s1 <= row_base_q;
		if (decide_act) begin
			result_q.rejected     <= reject;
			result_q.placed_layer <= reject ? 4'd0 : 4'(target_q);
			result_q.placed_slot  <= reject ? 4'd0 : 4'(slot);
			result_q.layers_used  <= reject ? 5'(lc_q) : 5'(new_layers);
			result_q.slots_used   <= reject ? 5'(cc_q) : 5'(new_cols);
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`OLP_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy)
	`OLP_ASSERT_NEXT(a_decide_done, clk, arst_n, decide_act, done)
	`OLP_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`OLP_ASSERT(a_reject_hold, clk, arst_n, done && result.rejected, lc_q == $past(lc_q))

endmodule

// File: dv/olp_placement_checker.sv
// Checker for the overlap layer placement unit: predicts each placement and compares results.
`timescale 1ns / 100ps

module olp_placement_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  olp_pkg::rect_t   rect,
	input  logic             done,
	input  olp_pkg::result_t result,
	output int               errors,
	output int               pending,
	output int               placed_cnt,
	output int               rejected_cnt,
	output int               grid_layers,
	output int               grid_cols
);

	import olp_pkg::*;

	localparam int unsigned NUM_LAYERS = DEF_MAX_LAYERS;
	localparam int unsigned NUM_SLOTS  = DEF_MAX_SLOTS;
	localparam int unsigned GRID_CELLS = NUM_LAYERS * NUM_SLOTS;

	rect_t       cell_rect [GRID_CELLS];
	bit          cell_full [GRID_CELLS];
	int unsigned layers_in_use;
	int unsigned cols_in_use;
	result_t     placement_q [$];
	result_t     oldest;
	int          err_n;
	int          placed_n;
	int          rejected_n;

	function automatic bit rects_collide(input rect_t a, input rect_t b);
		int dx;
		int dy;
		dx = int'($signed(a.center_x)) - int'($signed(b.center_x));
		dy = int'($signed(a.center_y)) - int'($signed(b.center_y));
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		return (2 * dx < int'(a.rect_width) + int'(b.rect_width)) &&
			(2 * dy < int'(a.rect_height) + int'(b.rect_height));
	endfunction

	// Updates the predicted grid and returns the result the block should report.
	function automatic result_t place_rect(input rect_t r);
		int unsigned target;
		int unsigned new_layers;
		int unsigned new_cols;
		int unsigned free_slots;
		int unsigned slot;
		result_t     res;
		target = 0;
		new_layers = layers_in_use;
		new_cols = cols_in_use;
		free_slots = 0;
		for (int l = 0; l < layers_in_use; l++) begin
			for (int s = 0; s < cols_in_use; s++) begin
				if (cell_full[l * NUM_SLOTS + s] && rects_collide(cell_rect[l * NUM_SLOTS + s], r))
					target = l + 1;
			end
		end
		if (target < layers_in_use) begin
			for (int s = 0; s < cols_in_use; s++) begin
				if (!cell_full[target * NUM_SLOTS + s])
					free_slots++;
			end
		end else begin
			new_layers = layers_in_use + 1;
			free_slots = cols_in_use;
		end
		if (free_slots == 0) begin
			new_cols = cols_in_use + 1;
			free_slots = 1;
		end
		res = '0;
		if (new_layers > NUM_LAYERS || new_cols > NUM_SLOTS) begin
			res.layers_used = layers_in_use[4:0];
			res.slots_used = cols_in_use[4:0];
			res.rejected = 1'b1;
			return res;
		end
		// Layers fill from slot 0 without holes, so the first free slot follows the used ones.
		slot = new_cols - free_slots;
		cell_rect[target * NUM_SLOTS + slot] = r;
		cell_full[target * NUM_SLOTS + slot] = 1'b1;
		layers_in_use = new_layers;
		cols_in_use = new_cols;
		res.placed_layer = target[3:0];
		res.placed_slot = slot[3:0];
		res.layers_used = layers_in_use[4:0];
		res.slots_used = cols_in_use[4:0];
		return res;
	endfunction

	task automatic note_mismatch(input string field, input logic [4:0] want, input logic [4:0] got);
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (cell_full[i]) cell_full[i] = 1'b0;
			layers_in_use = 0;
			cols_in_use = 0;
			placement_q.delete();
			err_n = 0;
			placed_n = 0;
			rejected_n = 0;
		end else begin
			// A result is retired before a transaction accepted at the same edge is predicted.
			if (done) begin
				if (placement_q.size() == 0) begin
					$display("%0t: result with no transaction outstanding, got %p", $time, result);
					err_n++;
				end else begin
					oldest = placement_q.pop_front();
					if (result !== oldest) begin
						err_n++;
						if (result.placed_layer !== oldest.placed_layer)
							note_mismatch("placed_layer", oldest.placed_layer, result.placed_layer);
						if (result.placed_slot !== oldest.placed_slot)
							note_mismatch("placed_slot", oldest.placed_slot, result.placed_slot);
						if (result.layers_used !== oldest.layers_used)
							note_mismatch("layers_used", oldest.layers_used, result.layers_used);
						if (result.slots_used !== oldest.slots_used)
							note_mismatch("slots_used", oldest.slots_used, result.slots_used);
						if (result.rejected !== oldest.rejected)
							note_mismatch("rejected", oldest.rejected, result.rejected);
					end
					if (oldest.rejected) rejected_n++;
					else placed_n++;
				end
			end
			if (start && !busy)
				placement_q.push_back(place_rect(rect));
		end
		errors <= err_n;
		pending <= placement_q.size();
		placed_cnt <= placed_n;
		rejected_cnt <= rejected_n;
		grid_layers <= layers_in_use;
		grid_cols <= cols_in_use;
	end

endmodule

// File: dv/tb_overlap_layer_placement_unit.sv
// Testbench top for the overlap layer placement unit: stimulus, checker hookup and verdict.
`timescale 1ns / 100ps

module tb_overlap_layer_placement_unit;
	import olp_pkg::*;

	localparam int NUM_RANDOM = 1250;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	rect_t   rect;
	logic    done;
	result_t result;

	int errors;
	int pending;
	int placed_cnt;
	int rejected_cnt;
	int grid_layers;
	int grid_cols;

	int hot_x [6];
	int hot_y [6];

	overlap_layer_placement_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.rect   (rect),
		.done   (done),
		.result (result)
	);

	olp_placement_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.rect         (rect),
		.done         (done),
		.result       (result),
		.errors       (errors),
		.pending      (pending),
		.placed_cnt   (placed_cnt),
		.rejected_cnt (rejected_cnt),
		.grid_layers  (grid_layers),
		.grid_cols    (grid_cols)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("%0t: timeout with %0d transactions outstanding", $time, pending);
		$display("tb_overlap_layer_placement_unit failed");
		$finish;
	end

	function automatic rect_t mk_rect(input int x, input int y, input int w, input int h);
		rect_t r;
		r.center_x = x[15:0];
		r.center_y = y[15:0];
		r.rect_width = w[14:0];
		r.rect_height = h[14:0];
		return r;
	endfunction

	function automatic int extreme_coord();
		case ($urandom_range(0, 3))
			0: return -32768;
			1: return -1;
			2: return 0;
			default: return 32767;
		endcase
	endfunction

	function automatic int extreme_size();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 1;
			2: return 32766;
			default: return 32767;
		endcase
	endfunction

	// Most rectangles are small and gather around a few hot spots so that stacks build up.
	function automatic rect_t random_rect();
		int k;
		int x;
		int y;
		k = $urandom_range(0, 5);
		x = hot_x[k] + int'($urandom_range(0, 600)) - 300;
		y = hot_y[k] + int'($urandom_range(0, 600)) - 300;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5:
				return mk_rect(x, y, $urandom_range(1, 400), $urandom_range(1, 400));
			6, 7:
				return mk_rect($urandom, $urandom, $urandom, $urandom);
			8:
				return mk_rect(x, y, $urandom_range(0, 1) ? 0 : $urandom_range(0, 500),
					$urandom_range(0, 1) ? $urandom_range(0, 500) : 0);
			default:
				return mk_rect(extreme_coord(), extreme_coord(), extreme_size(), extreme_size());
		endcase
	endfunction

	// Holds start high until the block takes the rectangle.
	task automatic send_rect(input rect_t r);
		start <= 1'b1;
		rect <= r;
		do @(posedge clk); while (busy);
	endtask

	initial begin
		rect_t lead_q [$];
		int    sent;
		int    burst;
		int    gap;
		bit    drained;
		arst_n = 1'b0;
		start = 1'b0;
		rect = '0;
		sent = 0;
		drained = 1'b0;
		foreach (hot_x[i]) begin
			hot_x[i] = int'($urandom_range(0, 60000)) - 30000;
			hot_y[i] = int'($urandom_range(0, 60000)) - 30000;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero-size rectangles at the same point do not overlap each other.
		lead_q.push_back(mk_rect(0, 0, 0, 0));
		lead_q.push_back(mk_rect(0, 0, 0, 0));
		lead_q.push_back(mk_rect(-32768, 32767, 32767, 32767));
		lead_q.push_back(mk_rect(32767, -32768, 32767, 32767));
		lead_q.push_back(mk_rect(-32768, -32768, 1, 1));
		lead_q.push_back(mk_rect(32767, 32767, 1, 1));
		lead_q.push_back(mk_rect(0, 0, 32767, 0));
		lead_q.push_back(mk_rect(0, 0, 32767, 32767));
		// A stack at the origin runs the layer count up to its limit and then one past it.
		repeat (15) lead_q.push_back(mk_rect(0, 0, 100, 100));
		foreach (lead_q[i]) send_rect(lead_q[i]);

		while (sent < NUM_RANDOM) begin
			burst = $urandom_range(1, 40);
			for (int b = 0; b < burst && sent < NUM_RANDOM; b++) begin
				send_rect(random_rect());
				sent++;
			end
			if (!drained && sent >= NUM_RANDOM / 2) begin
				drained = 1'b1;
				start <= 1'b0;
				@(posedge clk);
				wait (pending == 0);
				@(posedge clk);
			end else begin
				case ($urandom_range(0, 3))
					0: gap = 0;
					1: gap = $urandom_range(1, 4);
					2: gap = $urandom_range(5, 40);
					default: gap = $urandom_range(100, 300);
				endcase
				if (gap > 0) begin
					start <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end

		start <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (20) @(posedge clk);
		$display("Checked %0d placement transactions: %0d stored, %0d turned away at capacity.",
			placed_cnt + rejected_cnt, placed_cnt, rejected_cnt);
		$display("The grid ended at %0d layers by %0d columns.", grid_layers, grid_cols);
		if (errors == 0) begin
			$display("tb_overlap_layer_placement_unit passed");
		end else begin
			$display("%0d mismatching transactions", errors);
			$display("tb_overlap_layer_placement_unit failed");
		end
		$finish;
	end

endmodule
